// File: design/bsst_pkg.sv
`default_nettype none

package bsst_pkg;

    localparam int VALUE_W = 32;
    localparam int CAP_W   = 11;
    localparam int MIN_PAIR = 2;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [VALUE_W-1:0]        span_t;

    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

endpackage

`default_nettype wire

// File: design/bsst_store.sv
`default_nettype none

module bsst_store
    import bsst_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire value_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output value_t             rd_data
);

    value_t mem [DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/bounded_set_span_tracker_top.sv
`default_nettype none

// Bounded set span tracker. Each s_value item is added to a stored set of at most
// min(capacity, MAX_ENTRIES) signed numbers; when the set is full the item is
// rejected with m_status = 1 and nothing changes. Every item returns one result:
// the count held, whether two or more values are held, the longest span
// (max - min) and the shortest gap between sorted neighbors, both unsigned and
// zero while fewer than two values are held. An insert into a set already holding
// n values scans every stored entry through the single read port of the value
// memory, one entry per cycle, and then passes through S_GAP_LO, S_GAP_HI and
// S_EMIT, where its result is loaded; a rejected item goes straight from S_IDLE
// to S_EMIT. The next item is accepted no sooner than the cycle after the result
// is loaded, and later while m_ready holds the previous result back. One item is
// processed at a time. The memory needs no clearing pass after reset. Write
// capacity on the cfg channel only while the block is idle.

module bounded_set_span_tracker_top
    import bsst_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire value_t           s_value,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_status,
    output logic                  m_enough,
    output logic [CAP_W-1:0]      m_count_held,
    output span_t                 m_longest_span,
    output span_t                 m_shortest_span
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GAP_LO,
        S_GAP_HI,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   capacity_reg, capacity_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    value_t             largest_reg, largest_next;
    value_t             smallest_reg, smallest_next;
    span_t              gap_reg, gap_next;
    value_t             v_reg, v_next;
    value_t             lo_reg, lo_next;
    value_t             hi_reg, hi_next;
    logic               have_lo_reg, have_lo_next;
    logic               have_hi_reg, have_hi_next;
    logic               status_reg, status_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_status_reg, m_status_next;
    logic               m_enough_reg, m_enough_next;
    logic [CAP_W-1:0]   m_count_reg, m_count_next;
    span_t              m_longest_reg, m_longest_next;
    span_t              m_shortest_reg, m_shortest_next;

    logic [CMP_W-1:0]   held_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               set_full;
    logic               enough;
    logic               issue;
    logic               wr_en;
    value_t             rd_data;
    span_t              gap_lo_cand;
    span_t              gap_hi_cand;

    bsst_store #(
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (held_reg[AW-1:0]),
        .wr_data (v_reg),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign held_ext = CMP_W'(held_reg);
    assign cap_ext  = CMP_W'(capacity_reg);
    assign eff_cap  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
    assign set_full = held_ext >= eff_cap;
    assign enough   = held_ext >= CMP_W'(MIN_PAIR);

    assign issue = (state_reg == S_SCAN) && (rd_idx_reg < held_reg);
    assign wr_en = (state_reg == S_GAP_HI) && (status_reg == STATUS_STORED);

    assign gap_lo_cand = span_t'(v_reg - lo_reg);
    assign gap_hi_cand = span_t'(hi_reg - v_reg);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        capacity_next   = capacity_reg;
        held_next       = held_reg;
        largest_next    = largest_reg;
        smallest_next   = smallest_reg;
        gap_next        = gap_reg;
        v_next          = v_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        have_lo_next    = have_lo_reg;
        have_hi_next    = have_hi_reg;
        status_next     = status_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = 1'b0;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_enough_next   = m_enough_reg;
        m_count_next    = m_count_reg;
        m_longest_next  = m_longest_reg;
        m_shortest_next = m_shortest_reg;

        if (cfg_valid) begin
            capacity_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    v_next       = s_value;
                    have_lo_next = 1'b0;
                    have_hi_next = 1'b0;
                    rd_idx_next  = '0;
                    if (set_full) begin
                        status_next = STATUS_FULL;
                        state_next  = S_EMIT;
                    end else begin
                        status_next = STATUS_STORED;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    rd_idx_next  = CNT_W'(rd_idx_reg + 1'b1);
                    rd_pend_next = 1'b1;
                end
                // fold in the entry read last cycle
                if (rd_pend_reg) begin
                    if (rd_data <= v_reg && (!have_lo_reg || lo_reg <= rd_data)) begin
                        lo_next      = rd_data;
                        have_lo_next = 1'b1;
                    end
                    if (v_reg <= rd_data && (!have_hi_reg || rd_data <= hi_reg)) begin
                        hi_next      = rd_data;
                        have_hi_next = 1'b1;
                    end
                end
                if (!issue && !rd_pend_reg) begin
                    state_next = S_GAP_LO;
                end
            end
            S_GAP_LO: begin
                if (have_lo_reg && gap_lo_cand < gap_reg) begin
                    gap_next = gap_lo_cand;
                end
                if (held_reg == '0) begin
                    largest_next  = v_reg;
                    smallest_next = v_reg;
                end else begin
                    if (largest_reg <= v_reg) begin
                        largest_next = v_reg;
                    end
                    if (v_reg <= smallest_reg) begin
                        smallest_next = v_reg;
                    end
                end
                state_next = S_GAP_HI;
            end
            S_GAP_HI: begin
                if (have_hi_reg && gap_hi_cand < gap_reg) begin
                    gap_next = gap_hi_cand;
                end
                held_next  = CNT_W'(held_reg + 1'b1);
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = status_reg;
                    m_enough_next   = enough;
                    m_count_next    = held_ext[CAP_W-1:0];
                    m_longest_next  = enough ? span_t'(largest_reg - smallest_reg) : '0;
                    m_shortest_next = enough ? gap_reg : '0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            capacity_reg <= '0;
            held_reg     <= '0;
            largest_reg  <= '0;
            smallest_reg <= '0;
            gap_reg      <= '1;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            held_reg     <= held_next;
            largest_reg  <= largest_next;
            smallest_reg <= smallest_next;
            gap_reg      <= gap_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        v_reg          <= v_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        have_lo_reg    <= have_lo_next;
        have_hi_reg    <= have_hi_next;
        status_reg     <= status_next;
        rd_idx_reg     <= rd_idx_next;
        m_status_reg   <= m_status_next;
        m_enough_reg   <= m_enough_next;
        m_count_reg    <= m_count_next;
        m_longest_reg  <= m_longest_next;
        m_shortest_reg <= m_shortest_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_enough        = m_enough_reg;
    assign m_count_held    = m_count_reg;
    assign m_longest_span  = m_longest_reg;
    assign m_shortest_span = m_shortest_reg;

    a_held_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(held_reg) <= CMP_W'(MAX_ENTRIES))
        else $error("held count above memory depth");

    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> held_reg == CNT_W'($past(held_reg) + 1'b1))
        else $error("memory write without count increment");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && held_reg != $past(held_reg))
            |-> held_reg == CNT_W'($past(held_reg) + 1'b1))
        else $error("held count changed by other than one");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid_reg)) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> rd_idx_reg <= held_reg)
        else $error("scan index past held count");

endmodule

`default_nettype wire
